### rtl/mmsl_pkg.sv
// ----------------------------------------------------------------------------
// mmsl_pkg
// Shared types, constants and microcode encoding for the master soft limiter.
// ----------------------------------------------------------------------------
package mmsl_pkg;

  localparam int TanhEntries = 256;
  localparam int GainUnity   = 65536;
  localparam int MuffleScale = 62259;
  localparam int MuffleMin   = 66;
  localparam int CoefMax     = 65470;
  localparam int LimGain     = 68813;

  localparam longint LimScale = longint'(LimGain) * TanhEntries;
  localparam int ScaleW = $clog2(LimScale + 1);
  localparam int FracW  = 16;
  localparam int KIdxW  = ScaleW - FracW;
  localparam int AddrW  = $clog2(TanhEntries + 1);
  localparam int MulW   = (ScaleW + 1 > 26) ? ScaleW + 1 : 26;
  localparam int ProdW  = 2 * MulW;
  localparam int CfgW   = 17;
  localparam int SampW  = 24;
  localparam int OutW   = 16;
  localparam int TabW   = 15;

  typedef enum logic {
    RegMasterGain   = 1'b0,
    RegMuffleAmount = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SampW-1:0] in_left;
    logic signed [SampW-1:0] in_right;
  } in_word_t;

  typedef struct packed {
    logic signed [OutW-1:0] out_left;
    logic signed [OutW-1:0] out_right;
  } out_word_t;

  typedef enum logic [3:0] {
    StGainMul,
    StGainWb,
    StFiltMul,
    StFiltWb,
    StLimMul,
    StLimWb,
    StRomLo,
    StIntMul,
    StIntWb
  } step_e;

  typedef enum logic [1:0] {
    MulGain,
    MulFilt,
    MulLim,
    MulInterp
  } mul_sel_e;

  typedef enum logic [1:0] {
    JmpNone,
    JmpNoFilter,
    JmpNextCh
  } jmp_e;

  typedef struct packed {
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     gain_wb;
    logic     filt_wb;
    logic     lim_wb;
    logic     rom_lo;
    logic     int_wb;
    jmp_e     jmp;
    step_e    target;
  } ctrl_t;

  typedef logic [TabW-1:0] lim_tab_t [TanhEntries+1];

  // shift-subtract quotient, used only while building the constant table
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q, rem;
    int              i;
    q   = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= b) begin
        rem  = rem - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh table over |1.05 v| in [0, 8): t = (1 - e) / (1 + e), e = exp(-16 k / N)
  function automatic lim_tab_t build_lim_table();
    lim_tab_t          tab;
    longint unsigned   one, u, term, r, e, num, den, t;
    int                n, k;
    one  = 64'd1 << 32;
    u    = (64'd16 << 32) / TanhEntries;
    term = one;
    r    = one;
    e    = one;
    for (n = 1; n <= 20; n++) begin
      term = udiv64((term * u) >> 32, 64'(n));
      if (n[0]) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (k = 0; k <= TanhEntries; k++) begin
      num    = one - e;
      den    = one + e;
      t      = udiv64(num * 64'd32768 + (den >> 1), den);
      tab[k] = (t > 64'd32767) ? {TabW{1'b1}} : TabW'(t);
      e      = (e * r + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

endpackage

### rtl/mmsl_tanh_rom.sv
// ----------------------------------------------------------------------------
// mmsl_tanh_rom
// Constant tanh table with registered read.
// ----------------------------------------------------------------------------
module mmsl_tanh_rom (
  input  logic                        clk_i,
  input  logic [mmsl_pkg::AddrW-1:0]  addr_i,
  output logic [mmsl_pkg::TabW-1:0]   data_o
);
  import mmsl_pkg::*;

  localparam lim_tab_t LimTable = build_lim_table();

  logic [TabW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (addr_i > AddrW'(TanhEntries)) begin
      data_q <= {TabW{1'b1}};
    end else begin
      data_q <= LimTable[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

### rtl/mmsl_seq.sv
// ----------------------------------------------------------------------------
// mmsl_seq
// Microcode sequencer: step counter, control store and channel loop.
// ----------------------------------------------------------------------------
module mmsl_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            run_i,
  input  logic            hold_i,
  output mmsl_pkg::ctrl_t ctrl_o,
  output logic            ch_o,
  output logic            busy_o,
  output logic            done_o
);
  import mmsl_pkg::*;

  step_e step_q, step_d;
  logic  ch_q, ch_d;
  logic  busy_q, busy_d;
  ctrl_t uc;

  function automatic ctrl_t ucode(step_e st);
    ctrl_t c;
    c = '0;
    unique case (st)
      StGainMul: begin
        c.mul_en  = 1'b1;
        c.mul_sel = MulGain;
      end
      StGainWb: begin
        c.gain_wb = 1'b1;
        c.jmp     = JmpNoFilter;
        c.target  = StLimMul;
      end
      StFiltMul: begin
        c.mul_en  = 1'b1;
        c.mul_sel = MulFilt;
      end
      StFiltWb: c.filt_wb = 1'b1;
      StLimMul: begin
        c.mul_en  = 1'b1;
        c.mul_sel = MulLim;
      end
      StLimWb:  c.lim_wb = 1'b1;
      StRomLo:  c.rom_lo = 1'b1;
      StIntMul: begin
        c.mul_en  = 1'b1;
        c.mul_sel = MulInterp;
      end
      StIntWb: begin
        c.int_wb = 1'b1;
        c.jmp    = JmpNextCh;
        c.target = StGainMul;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StGainMul;
      ch_q   <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      ch_q   <= ch_d;
      busy_q <= busy_d;
    end
  end

  always_comb begin
    uc     = ucode(step_q);
    step_d = step_q;
    ch_d   = ch_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (busy_q) begin
      ctrl_o = uc;
    end else begin
      ctrl_o = '0;
    end
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = StGainMul;
        ch_d   = 1'b0;
      end
    end else begin
      unique case (uc.jmp)
        JmpNone:     step_d = step_e'(step_q + 4'd1);
        JmpNoFilter: step_d = run_i ? step_e'(step_q + 4'd1) : uc.target;
        JmpNextCh: begin
          if (!ch_q) begin
            ch_d   = 1'b1;
            step_d = uc.target;
          end else if (!hold_i) begin
            busy_d = 1'b0;
            ch_d   = 1'b0;
            step_d = uc.target;
            done_o = 1'b1;
          end
        end
        default: step_d = StGainMul;
      endcase
    end
  end

  assign ch_o   = ch_q;
  assign busy_o = busy_q;

  a_idle_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (step_q == StGainMul) && !ch_q)
    else $error("sequencer idle away from first step");

  a_ch_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ch_q) |-> (step_q == StGainMul) && $past(step_q == StIntWb))
    else $error("channel switch outside loop jump");

endmodule

### rtl/mmsl_datapath.sv
// ----------------------------------------------------------------------------
// mmsl_datapath
// Shared multiplier, filter states and limiter interpolation datapath.
// ----------------------------------------------------------------------------
module mmsl_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  mmsl_pkg::in_word_t          in_word_i,
  input  logic [mmsl_pkg::CfgW-1:0]   gain_i,
  input  logic [mmsl_pkg::CfgW-1:0]   coef_i,
  input  mmsl_pkg::ctrl_t             ctrl_i,
  input  logic                        ch_i,
  output mmsl_pkg::out_word_t         result_o
);
  import mmsl_pkg::*;

  logic signed [SampW-1:0] x_l_q, x_r_q, v_q, filt_l_q, filt_r_q;
  logic signed [SampW-1:0] x_sel, s_sel, s_new;
  logic signed [SampW:0]   diff, inc;
  logic [SampW-1:0]        mag;
  logic signed [MulW-1:0]  op_a, op_b;
  logic signed [ProdW-1:0] prod, p_q, p_rnd, p_sh;
  logic [KIdxW-1:0]        k_now;
  logic [FracW-1:0]        f_now, f_q, delta;
  logic [AddrW-1:0]        k_q, rom_addr;
  logic                    sat_q;
  logic [TabW-1:0]         rom_data, lo_q, interp_diff, mag_o;
  logic [TabW+1:0]         sum;
  logic signed [OutW-1:0]  res_now, res_l_q;

  assign x_sel = ch_i ? x_r_q : x_l_q;
  assign s_sel = ch_i ? filt_r_q : filt_l_q;
  assign diff  = {v_q[SampW-1], v_q} - {s_sel[SampW-1], s_sel};
  assign mag   = v_q[SampW-1] ? SampW'(~v_q + SampW'(1)) : SampW'(v_q);

  assign p_rnd = p_q + ProdW'(32768);
  assign p_sh  = p_rnd >>> 16;
  assign inc   = p_sh[SampW:0];
  assign s_new = SampW'({s_sel[SampW-1], s_sel} + inc);

  assign k_now = p_q[23+FracW +: KIdxW];
  assign f_now = p_q[23 +: FracW];

  assign rom_addr    = ctrl_i.lim_wb ? AddrW'(k_now) : AddrW'(k_q + AddrW'(1));
  assign interp_diff = rom_data - lo_q;

  mmsl_tanh_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  always_comb begin
    case (ctrl_i.mul_sel)
      MulGain: begin
        op_a = MulW'(x_sel);
        op_b = MulW'(gain_i);
      end
      MulFilt: begin
        op_a = MulW'(diff);
        op_b = MulW'(coef_i);
      end
      MulLim: begin
        op_a = MulW'(mag);
        op_b = MulW'(LimScale);
      end
      MulInterp: begin
        op_a = MulW'(interp_diff);
        op_b = MulW'(f_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = ProdW'(op_a) * ProdW'(op_b);

  // interpolated magnitude, saturated, sign of v restored
  assign delta = p_sh[FracW-1:0];
  assign sum   = {2'b00, lo_q} + {1'b0, delta};
  assign mag_o = (sat_q || sum > (TabW+2)'(32767)) ? {TabW{1'b1}} : sum[TabW-1:0];
  assign res_now = v_q[SampW-1] ? -$signed({1'b0, mag_o}) : $signed({1'b0, mag_o});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_l_q <= in_word_i.in_left;
      x_r_q <= in_word_i.in_right;
    end
    if (ctrl_i.mul_en) begin
      p_q <= prod;
    end
    if (ctrl_i.gain_wb) begin
      v_q <= p_sh[SampW-1:0];
    end else if (ctrl_i.filt_wb) begin
      v_q <= s_new;
    end
    if (ctrl_i.lim_wb) begin
      k_q   <= AddrW'(k_now);
      f_q   <= f_now;
      sat_q <= k_now >= KIdxW'(TanhEntries);
    end
    if (ctrl_i.rom_lo) begin
      lo_q <= rom_data;
    end
    if (ctrl_i.int_wb && !ch_i) begin
      res_l_q <= res_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_l_q <= '0;
      filt_r_q <= '0;
    end else if (ctrl_i.filt_wb) begin
      if (ch_i) begin
        filt_r_q <= s_new;
      end else begin
        filt_l_q <= s_new;
      end
    end
  end

  assign result_o = '{out_left: res_l_q, out_right: res_now};

  a_filt_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(filt_l_q) |-> $past(ctrl_i.filt_wb && !ch_i))
    else $error("left filter state changed outside its write step");

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.int_wb && !ch_i |=> res_l_q != 16'sh8000)
    else $error("left result outside symmetric range");

endmodule

### rtl/master_muffle_soft_limiter.sv
// ----------------------------------------------------------------------------
// master_muffle_soft_limiter
// Stereo master stage: gain, optional one-pole muffle low-pass, tanh limiter.
//
// Port     Handshake                   Word
// in       in_valid_i / in_stall_o     in_word_t  (in_left, in_right, Q4.20)
// out      out_valid_o / out_stall_i   out_word_t (out_left, out_right, Q1.15)
// cfg      cfg_we_i                    cfg_index_i, cfg_data_i
//
// An item runs through the one shared multiplier: nine microcode steps per
// channel with the filter running, seven with it bypassed, channels in turn,
// two table reads per channel. The input stalls while an item is in flight,
// so the next word is taken only once the sequencer is idle again.
// Reset: gain unity, muffle off, both filter states zero; no clearing pass.
// A result waits in the output register; a following item holds at its last
// step while that register is stalled.
// ----------------------------------------------------------------------------
module master_muffle_soft_limiter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mmsl_pkg::in_word_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mmsl_pkg::out_word_t         out_word_o,
  input  logic                        cfg_we_i,
  input  mmsl_pkg::cfg_reg_e          cfg_index_i,
  input  logic [mmsl_pkg::CfgW-1:0]   cfg_data_i
);
  import mmsl_pkg::*;

  logic [CfgW-1:0] gain_q, muffle_q, m_clamp, gain_eff, coef_d, coef_q;
  logic [32:0]     cprod;
  logic            run_d, run_q;
  logic            start, busy, done, hold, ch;
  logic            out_valid_q;
  out_word_t       out_word_q, result;
  ctrl_t           ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= CfgW'(GainUnity);
      muffle_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMasterGain:   gain_q   <= cfg_data_i;
        RegMuffleAmount: muffle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign gain_eff = (gain_q > CfgW'(GainUnity)) ? CfgW'(GainUnity) : gain_q;
  assign m_clamp  = (muffle_q > CfgW'(GainUnity)) ? CfgW'(GainUnity) : muffle_q;
  assign cprod    = 33'(m_clamp) * 33'(MuffleScale) + 33'(32768);
  assign coef_d   = CfgW'(GainUnity) - CfgW'(cprod >> 16);
  assign run_d    = (m_clamp >= CfgW'(MuffleMin)) && (coef_d <= CfgW'(CoefMax));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CfgW'(GainUnity);
      run_q  <= 1'b0;
    end else begin
      coef_q <= coef_d;
      run_q  <= run_d;
    end
  end

  assign start      = in_valid_i && !busy;
  assign in_stall_o = busy;
  assign hold       = out_valid_q && out_stall_i;

  mmsl_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .run_i   (run_q),
    .hold_i  (hold),
    .ctrl_o  (ctrl),
    .ch_o    (ch),
    .busy_o  (busy),
    .done_o  (done)
  );

  mmsl_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .in_word_i (in_word_i),
    .gain_i    (gain_eff),
    .coef_i    (coef_q),
    .ctrl_i    (ctrl),
    .ch_i      (ch),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= done || hold;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("accepted word did not start the sequencer");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> out_valid_q)
    else $error("item finished without loading the output register");

endmodule
